// ----- rtl/pqsi_pkg.sv -----
// Types and codes shared by the sorted-insert priority queue modules.
package pqsi_pkg;

    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 8;
    localparam int OCC_W   = 5;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_REMOVE = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } t_cell_cmd;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]         prio;
    } t_entry;

    typedef struct packed {
        t_cell_cmd cmd;
        t_entry    new_entry;
    } t_cell_ctl;

    typedef struct packed {
        t_action                   action;
        logic signed [VALUE_W-1:0] item_value;
        logic [PRIO_W-1:0]         item_priority;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] out_value;
        logic [PRIO_W-1:0]         out_priority;
        t_status                   status;
        logic [OCC_W-1:0]          occupancy;
    } t_out_item;

endpackage

// ----- rtl/pqsi_cell.sv -----
// One queue slot: holds an entry, compares it with a new pair and shifts with its neighbors.
module pqsi_cell (
    input  logic              i_clk,
    input  pqsi_pkg::t_cell_ctl i_ctl,
    input  logic              i_valid,
    input  logic              i_left_keep,
    input  pqsi_pkg::t_entry  i_left,
    input  pqsi_pkg::t_entry  i_right,
    output pqsi_pkg::t_entry  o_entry,
    output logic              o_keep
);
    import pqsi_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // Stay ahead of the new pair when our priority is at least as high.
    assign o_keep  = i_valid && (r_entry.prio >= i_ctl.new_entry.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.cmd)
            CELL_INSERT: begin
                if (o_keep) begin
                    n_entry = r_entry;
                end else if (i_left_keep) begin
                    n_entry = i_ctl.new_entry;
                end else begin
                    n_entry = i_left;
                end
            end
            CELL_REMOVE: begin
                n_entry = i_right;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ----- rtl/priority_queue_sorted_insert.sv -----
// The result strobe rises in the cycle after the accepted beat.
// Throughput: one beat per cycle; busy never rises, since the whole cell row
// moves in the same edge (parallel compares, one-place shift toward either end).
// Reset clears the entry count and the result strobe; slot contents stay
// undefined until written. The receiver cannot stall the result.
module priority_queue_sorted_insert #(
    parameter int CAPACITY = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  pqsi_pkg::t_in_item  i_item,
    output logic                o_result_valid,
    output pqsi_pkg::t_out_item o_result
);
    import pqsi_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_result_valid;
    t_out_item        r_result;
    t_out_item        n_result;
    t_cell_ctl        w_ctl;
    logic             w_accept;
    logic             w_full;

    t_entry w_entry [CAPACITY];
    t_entry w_left  [CAPACITY];
    t_entry w_right [CAPACITY];
    logic   w_keep  [CAPACITY];
    logic   w_lkeep [CAPACITY];
    logic   w_valid [CAPACITY];

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CNT_W'(CAPACITY));

    always_comb begin
        w_ctl.new_entry.value = i_item.item_value;
        w_ctl.new_entry.prio  = i_item.item_priority;
        w_ctl.cmd             = CELL_HOLD;
        n_count               = r_count;
        n_result.out_value    = '0;
        n_result.out_priority = '0;
        n_result.status       = ST_DONE;
        if (i_item.action == ACT_REMOVE) begin
            if (r_count == '0) begin
                n_result.status = ST_EMPTY;
            end else begin
                w_ctl.cmd             = w_accept ? CELL_REMOVE : CELL_HOLD;
                n_count               = r_count - CNT_W'(1);
                n_result.out_value    = w_entry[0].value;
                n_result.out_priority = w_entry[0].prio;
            end
        end else begin
            if (w_full) begin
                n_result.status = ST_FULL;
            end else begin
                w_ctl.cmd = w_accept ? CELL_INSERT : CELL_HOLD;
                n_count   = r_count + CNT_W'(1);
            end
        end
        n_result.occupancy = OCC_W'(n_count);
    end

    // Wire each slot to its neighbors; the ends see fixed stand-ins.
    always_comb begin
        w_lkeep[0]          = 1'b1;
        w_left[0]           = w_ctl.new_entry;
        w_right[CAPACITY-1] = w_entry[CAPACITY-1];
        for (int i = 1; i < CAPACITY; i++) begin
            w_lkeep[i]  = w_keep[i-1];
            w_left[i]   = w_entry[i-1];
            w_right[i-1] = w_entry[i];
        end
        for (int i = 0; i < CAPACITY; i++) begin
            w_valid[i] = (CNT_W'(i) < r_count);
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        pqsi_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_valid     (w_valid[g]),
            .i_left_keep (w_lkeep[g]),
            .i_left      (w_left[g]),
            .i_right     (w_right[g]),
            .o_entry     (w_entry[g]),
            .o_keep      (w_keep[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count        <= '0;
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> o_result_valid)
        else $error("accepted beat produced no result");

    a_empty_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_item.action == ACT_REMOVE && r_count == '0)
        |=> (o_result.status == ST_EMPTY && r_count == '0))
        else $error("remove on empty queue misreported");

    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (w_entry[0].prio >= w_entry[1].prio))
        else $error("head entry out of priority order");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_item.action == ACT_INSERT && w_full)
        |=> ($stable(r_count) && o_result.status == ST_FULL))
        else $error("insert on full queue not dropped");
`endif

endmodule
